/* src/sem_pkg.sv */
package sem_pkg;

  // Field and register widths
  localparam int PIX_W          = 8;
  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 12;
  localparam int CFG_DATA_W     = 12;
  localparam int CFG_IDX_W      = 1;

  // Gradient and root datapath widths
  localparam int GRAD_W = 12;
  localparam int SUM_W  = 17;
  localparam int ROOT_W = 16;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // Request codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // 3x3 window, row-major: 0..2 top, 3..5 middle, 6..8 bottom
  typedef logic [8:0][PIX_W-1:0] win_t;

  // Window sides that fall outside the frame
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } edge_mask_t;

endpackage

/* src/sem_ram.sv */
module sem_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sem_grad.sv */
module sem_grad (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  sem_pkg::win_t              window_i,
  input  sem_pkg::edge_mask_t        mask_i,
  output logic [sem_pkg::SUM_W-1:0]  sum_o
);
  import sem_pkg::*;

  pix_t                     p [9];
  logic signed [GRAD_W-1:0] pe [9];
  logic signed [GRAD_W-1:0] gx, gy;
  pix_t                     gx_d, gy_d;
  pix_t                     gx_q, gy_q;
  logic [2*PIX_W-1:0]       gx_sq, gy_sq;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p[i] = window_i[i];
    end
    if (mask_i.top) begin
      p[0] = '0; p[1] = '0; p[2] = '0;
    end
    if (mask_i.bottom) begin
      p[6] = '0; p[7] = '0; p[8] = '0;
    end
    if (mask_i.left) begin
      p[0] = '0; p[3] = '0; p[6] = '0;
    end
    if (mask_i.right) begin
      p[2] = '0; p[5] = '0; p[8] = '0;
    end
    for (int i = 0; i < 9; i++) begin
      pe[i] = $signed({{(GRAD_W-PIX_W){1'b0}}, p[i]});
    end
  end

  assign gx = (pe[2] - pe[0]) + ((pe[5] - pe[3]) <<< 1) + (pe[8] - pe[6]);
  assign gy = (pe[0] + (pe[1] <<< 1) + pe[2]) - (pe[6] + (pe[7] <<< 1) + pe[8]);

  // Clamp both sums to 0..255
  always_comb begin
    if (gx[GRAD_W-1]) begin
      gx_d = '0;
    end else if (|gx[GRAD_W-2:PIX_W]) begin
      gx_d = '1;
    end else begin
      gx_d = gx[PIX_W-1:0];
    end
    if (gy[GRAD_W-1]) begin
      gy_d = '0;
    end else if (|gy[GRAD_W-2:PIX_W]) begin
      gy_d = '1;
    end else begin
      gy_d = gy[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
  end

  assign gx_sq = gx_q * gx_q;
  assign gy_sq = gy_q * gy_q;
  assign sum_o = {1'b0, gx_sq} + {1'b0, gy_sq};

endmodule

/* src/sem_sqrt.sv */
module sem_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sem_pkg::SUM_W-1:0] radicand_i,
  output logic                      done_o,
  output logic [sem_pkg::PIX_W-1:0] root_o
);
  import sem_pkg::*;

  localparam logic [ROOT_W-1:0] SEED_BIT = ROOT_W'(1) << (ROOT_W - 2);
  localparam logic [ROOT_W-1:0] ROOT_CAP = ROOT_W'(255);

  logic [ROOT_W-1:0] rem_q, rem_d;
  logic [ROOT_W-1:0] res_q, res_d;
  logic [ROOT_W-1:0] bit_q, bit_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ROOT_W:0]   trial;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};

  always_comb begin
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      done_d = 1'b0;
      if (radicand_i[SUM_W-1]) begin
        // Root is 256 or more: cap right away
        res_d  = ROOT_CAP;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        rem_d  = radicand_i[ROOT_W-1:0];
        res_d  = '0;
        bit_d  = SEED_BIT;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      // One result bit per cycle
      if ({1'b0, rem_q} >= trial) begin
        rem_d = rem_q - trial[ROOT_W-1:0];
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == ROOT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[PIX_W-1:0];

endmodule

/* src/sobel_edge_magnitude.sv */
// Channel  Direction  Handshake               Payload
// cfg      in         cfg_we_i                cfg_index_i, cfg_data_i
// in       in         in_valid_i/in_ready_o   req_type_i, pixel_value_i
// out      out        out_valid_o/out_ready_i edge_value_o, frame_last_o
//
// A pixel that yields no result passes S_IDLE and S_PUSH only; one that
// yields a result also waits for the one-bit-per-cycle square root (8 steps)
// behind the line store read and the gradient register; the root skips its
// steps when it caps at 255. A flush pushes zero pixels through S_FETCH and
// S_PUSH. After reset the block clears both line stores, one entry per cycle,
// all MAX_WIDTH entries, before it takes the first word. The output register
// lets the next word enter while a result waits for out_ready_i.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               req_type_i,
  input  logic [sem_pkg::PIX_W-1:0]          pixel_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sem_pkg::PIX_W-1:0]          edge_value_o,
  output logic                               frame_last_o
);
  import sem_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int Q_W   = $clog2(MAX_WIDTH + 3);
  localparam int ROW_W = FRAME_HEIGHT_W;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_FETCH = 8'b0000_0100,
    S_PUSH  = 8'b0000_1000,
    S_GRAD  = 8'b0001_0000,
    S_START = 8'b0010_0000,
    S_ROOT  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e                    state_q, state_d;
  logic [FRAME_WIDTH_W-1:0]  cfg_width_q, cfg_width_d;
  logic [FRAME_HEIGHT_W-1:0] cfg_height_q, cfg_height_d;
  logic [COL_W-1:0]          clr_addr_q, clr_addr_d;
  logic [COL_W-1:0]          in_col_q, in_col_d;
  logic [ROW_W-1:0]          in_row_q, in_row_d;
  logic [COL_W-1:0]          out_col_q, out_col_d;
  logic [ROW_W-1:0]          out_row_q, out_row_d;
  logic [Q_W-1:0]            queue_q, queue_d;
  logic [Q_W-1:0]            owed_q, owed_d;
  logic                      draining_q, draining_d;
  logic                      flush_q, flush_d;
  logic                      out_valid_q, out_valid_d;
  win_t                      window_q, window_d;
  pix_t                      pix_q, pix_d;
  logic                      last_pend_q, last_pend_d;
  pix_t                      edge_q;
  logic                      last_q;

  logic [WID_W-1:0]          eff_w;
  logic [ROW_W-1:0]          eff_h;
  logic                      in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;
  logic [Q_W:0]              w_plus2;
  logic                      q_full, q_near, drain_go;
  logic                      ram_we, grad_en, root_start, out_load;
  logic [COL_W-1:0]          ram_addr;
  pix_t                      upper_wdata, lower_wdata, upper_rd, lower_rd, push_val;
  edge_mask_t                mask;
  logic [SUM_W-1:0]          grad_sum;
  logic                      root_done;
  pix_t                      root;

  // Effective geometry
  always_comb begin
    if (cfg_width_q == '0) begin
      eff_w = WID_W'(1);
    end else if (int'(cfg_width_q) > MAX_WIDTH) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(cfg_width_q);
    end
    eff_h = (cfg_height_q == '0) ? ROW_W'(1) : cfg_height_q;
  end

  assign in_col_wrap  = (WID_W'(in_col_q) + WID_W'(1)) >= eff_w;
  assign in_row_wrap  = ({1'b0, in_row_q} + (ROW_W+1)'(1)) >= {1'b0, eff_h};
  assign out_col_wrap = (WID_W'(out_col_q) + WID_W'(1)) >= eff_w;
  assign out_row_wrap = ({1'b0, out_row_q} + (ROW_W+1)'(1)) >= {1'b0, eff_h};

  assign w_plus2 = (Q_W+1)'(eff_w) + (Q_W+1)'(2);
  assign q_full  = {1'b0, queue_q} >= w_plus2;
  assign q_near  = ({1'b0, queue_q} + (Q_W+1)'(1)) >= w_plus2;
  assign drain_go = draining_q || (queue_q != '0 && in_row_q == '0 && in_col_q == '0);

  assign push_val = flush_q ? '0 : pix_q;

  assign mask.top    = (out_row_q == '0);
  assign mask.bottom = out_row_wrap;
  assign mask.left   = (out_col_q == '0);
  assign mask.right  = out_col_wrap;

  always_comb begin
    state_d      = state_q;
    cfg_width_d  = cfg_width_q;
    cfg_height_d = cfg_height_q;
    clr_addr_d   = clr_addr_q;
    in_col_d     = in_col_q;
    in_row_d     = in_row_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    queue_d      = queue_q;
    owed_d       = owed_q;
    draining_d   = draining_q;
    flush_d      = flush_q;
    window_d     = window_q;
    pix_d        = pix_q;
    last_pend_d  = last_pend_q;
    ram_we       = 1'b0;
    ram_addr     = in_col_q;
    upper_wdata  = lower_rd;
    lower_wdata  = push_val;
    grad_en      = 1'b0;
    root_start   = 1'b0;
    out_load     = 1'b0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  cfg_width_d  = cfg_data_i[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: cfg_height_d = cfg_data_i[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_addr    = clr_addr_q;
        upper_wdata = '0;
        lower_wdata = '0;
        clr_addr_d  = clr_addr_q + COL_W'(1);
        if (clr_addr_q == COL_W'(MAX_WIDTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        // The line stores read in_col_q here, so S_PUSH has the data
        if (in_valid_i) begin
          if (req_type_i == REQ_PIXEL) begin
            if (!draining_q) begin
              pix_d   = pixel_value_i;
              flush_d = 1'b0;
              state_d = S_PUSH;
            end
          end else if (drain_go) begin
            flush_d = 1'b1;
            if (!draining_q) begin
              draining_d = 1'b1;
              owed_d     = queue_q;
            end
            state_d = q_full ? S_GRAD : S_PUSH;
          end
        end
      end
      S_FETCH: begin
        state_d = S_PUSH;
      end
      S_PUSH: begin
        ram_we      = 1'b1;
        window_d[0] = window_q[1];
        window_d[1] = window_q[2];
        window_d[2] = upper_rd;
        window_d[3] = window_q[4];
        window_d[4] = window_q[5];
        window_d[5] = lower_rd;
        window_d[6] = window_q[7];
        window_d[7] = window_q[8];
        window_d[8] = push_val;
        if (in_col_wrap) begin
          in_col_d = '0;
          in_row_d = in_row_wrap ? '0 : in_row_q + ROW_W'(1);
        end else begin
          in_col_d = in_col_q + COL_W'(1);
        end
        queue_d = queue_q + Q_W'(1);
        if (q_near) begin
          state_d = S_GRAD;
        end else begin
          state_d = flush_q ? S_FETCH : S_IDLE;
        end
      end
      S_GRAD: begin
        grad_en     = 1'b1;
        last_pend_d = (out_row_q == eff_h - ROW_W'(1))
                      && (WID_W'(out_col_q) == eff_w - WID_W'(1));
        if (out_col_wrap) begin
          out_col_d = '0;
          out_row_d = out_row_wrap ? '0 : out_row_q + ROW_W'(1);
        end else begin
          out_col_d = out_col_q + COL_W'(1);
        end
        queue_d = queue_q - Q_W'(1);
        if (flush_q) begin
          owed_d = owed_q - Q_W'(1);
          // Last owed result: back to the start of a frame
          if (owed_q == Q_W'(1)) begin
            draining_d = 1'b0;
            queue_d    = '0;
            in_col_d   = '0;
            in_row_d   = '0;
            out_col_d  = '0;
            out_row_d  = '0;
          end
        end
        state_d = S_START;
      end
      S_START: begin
        root_start = 1'b1;
        state_d    = S_ROOT;
      end
      S_ROOT: begin
        if (root_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cfg_width_q  <= FRAME_WIDTH_RST;
      cfg_height_q <= FRAME_HEIGHT_RST;
      clr_addr_q   <= '0;
      in_col_q     <= '0;
      in_row_q     <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      queue_q      <= '0;
      owed_q       <= '0;
      draining_q   <= 1'b0;
      flush_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      window_q     <= '0;
    end else begin
      state_q      <= state_d;
      cfg_width_q  <= cfg_width_d;
      cfg_height_q <= cfg_height_d;
      clr_addr_q   <= clr_addr_d;
      in_col_q     <= in_col_d;
      in_row_q     <= in_row_d;
      out_col_q    <= out_col_d;
      out_row_q    <= out_row_d;
      queue_q      <= queue_d;
      owed_q       <= owed_d;
      draining_q   <= draining_d;
      flush_q      <= flush_d;
      out_valid_q  <= out_valid_d;
      window_q     <= window_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q       <= pix_d;
    last_pend_q <= last_pend_d;
    if (out_load) begin
      edge_q <= root;
      last_q <= last_pend_q;
    end
  end

  // Row two back
  sem_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (upper_wdata),
    .rdata_o (upper_rd)
  );

  // Row one back
  sem_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_lower (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (lower_wdata),
    .rdata_o (lower_rd)
  );

  sem_grad u_grad (
    .clk_i    (clk_i),
    .en_i     (grad_en),
    .window_i (window_q),
    .mask_i   (mask),
    .sum_o    (grad_sum)
  );

  sem_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (grad_sum),
    .done_o     (root_done),
    .root_o     (root)
  );

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign edge_value_o = edge_q;
  assign frame_last_o = last_q;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import sem_pkg::*;

  localparam int          MAX_W         = 1024;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned STALL_LIMIT   = 20000;

  typedef struct packed {
    pix_t magnitude;
    logic frame_end;
  } edge_exp_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic                  req_type_i    = REQ_PIXEL;
  pix_t                  pixel_value_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  pix_t                  edge_value_o;
  logic                  frame_last_o;

  sobel_edge_magnitude #(
    .MAX_WIDTH(MAX_W)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .pixel_value_i (pixel_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .edge_value_o  (edge_value_o),
    .frame_last_o  (frame_last_o)
  );

  // Edge predictor state
  logic [FRAME_WIDTH_W-1:0]  cfg_width;
  logic [FRAME_HEIGHT_W-1:0] cfg_height;
  pix_t                      row_two_back [MAX_W];
  pix_t                      row_one_back [MAX_W];
  pix_t                      win_px [9];
  int unsigned               push_col, push_row, pop_col, pop_row;
  int unsigned               in_flight, owed_edges;
  bit                        draining;

  edge_exp_t   expected_edges [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_left    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned words_used    = 0;
  int unsigned dropped_words = 0;
  int unsigned edges_checked = 0;
  int unsigned geometries    = 0;
  int unsigned fail_cnt      = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reset_predictor();
    cfg_width  = FRAME_WIDTH_RST;
    cfg_height = FRAME_HEIGHT_RST;
    for (int i = 0; i < MAX_W; i++) begin
      row_two_back[i] = '0;
      row_one_back[i] = '0;
    end
    for (int i = 0; i < 9; i++) win_px[i] = '0;
    push_col   = 0;
    push_row   = 0;
    pop_col    = 0;
    pop_row    = 0;
    in_flight  = 0;
    owed_edges = 0;
    draining   = 1'b0;
  endfunction

  function automatic int unsigned width_eff();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_W) return MAX_W;
    return cfg_width;
  endfunction

  function automatic int unsigned height_eff();
    if (cfg_height == 0) return 1;
    return cfg_height;
  endfunction

  function automatic int unsigned floor_root(int unsigned x);
    int unsigned r;
    int unsigned trial;
    r = 0;
    for (int b = 9; b >= 0; b--) begin
      trial = r | (32'd1 << b);
      if (trial * trial <= x) r = trial;
    end
    return r;
  endfunction

  function automatic void shift_in(pix_t v);
    int unsigned w, h, c;
    w = width_eff();
    h = height_eff();
    c = push_col % MAX_W;
    for (int r = 0; r < 3; r++) begin
      win_px[r*3]   = win_px[r*3+1];
      win_px[r*3+1] = win_px[r*3+2];
    end
    win_px[2] = row_two_back[c];
    win_px[5] = row_one_back[c];
    win_px[8] = v;
    row_two_back[c] = row_one_back[c];
    row_one_back[c] = v;
    if (push_col + 1 >= w) begin
      push_col = 0;
      push_row = (push_row + 1 >= h) ? 0 : push_row + 1;
    end else begin
      push_col++;
    end
    in_flight++;
  endfunction

  function automatic void emit_edge();
    int unsigned w, h, mag;
    int          p [9];
    int          gx, gy;
    edge_exp_t   word;
    w = width_eff();
    h = height_eff();
    for (int i = 0; i < 9; i++) p[i] = win_px[i];
    // zero the neighbors that fall outside the frame
    if (pop_row == 0) begin
      p[0] = 0; p[1] = 0; p[2] = 0;
    end
    if (pop_row + 1 >= h) begin
      p[6] = 0; p[7] = 0; p[8] = 0;
    end
    if (pop_col == 0) begin
      p[0] = 0; p[3] = 0; p[6] = 0;
    end
    if (pop_col + 1 >= w) begin
      p[2] = 0; p[5] = 0; p[8] = 0;
    end
    gx = (p[2] - p[0]) + 2 * (p[5] - p[3]) + (p[8] - p[6]);
    gy = (p[0] + 2 * p[1] + p[2]) - (p[6] + 2 * p[7] + p[8]);
    gx = (gx < 0) ? 0 : (gx > 255) ? 255 : gx;
    gy = (gy < 0) ? 0 : (gy > 255) ? 255 : gy;
    mag = floor_root(gx * gx + gy * gy);
    if (mag > 255) mag = 255;
    word.magnitude = pix_t'(mag);
    word.frame_end = (pop_row == h - 1 && pop_col == w - 1);
    expected_edges.insert(expected_edges.size(), word);
    if (pop_col + 1 >= w) begin
      pop_col = 0;
      pop_row = (pop_row + 1 >= h) ? 0 : pop_row + 1;
    end else begin
      pop_col++;
    end
    in_flight--;
  endfunction

  function automatic void predict_edge(logic req, pix_t v);
    int unsigned w, guard;
    w = width_eff();
    if (req == REQ_PIXEL) begin
      if (draining) begin
        dropped_words++;
        return;
      end
      words_used++;
      shift_in(v);
      if (in_flight >= w + 2) emit_edge();
      return;
    end
    if (!draining) begin
      // drain opens only at a frame boundary with something pending
      if (in_flight == 0 || push_row != 0 || push_col != 0) begin
        dropped_words++;
        return;
      end
      draining   = 1'b1;
      owed_edges = in_flight;
    end
    words_used++;
    guard = 0;
    while (in_flight < w + 2 && guard < MAX_W + 2) begin
      shift_in('0);
      guard++;
    end
    emit_edge();
    owed_edges--;
    if (owed_edges == 0) begin
      draining  = 1'b0;
      in_flight = 0;
      push_col  = 0;
      push_row  = 0;
      pop_col   = 0;
      pop_row   = 0;
    end
  endfunction

  function automatic pix_t rand_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return pix_t'($urandom_range(255));
    endcase
  endfunction

  function automatic void pick_geometry(output int unsigned w, output int unsigned h);
    case ($urandom_range(9))
      0: begin
        w = $urandom_range(0, 2);
        h = $urandom_range(0, 4);
      end
      1: begin
        w = $urandom_range(13, 48);
        h = $urandom_range(1, 2);
      end
      default: begin
        w = $urandom_range(3, 10);
        h = $urandom_range(1, 6);
      end
    endcase
  endfunction

  function automatic void set_idle(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endfunction

  // Offer one word; return at a falling edge with valid still high.
  task automatic send_word(logic req, pix_t v);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    pixel_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    predict_edge(req, v);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every pending result, then let the pipe go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_edges.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_geometry(int unsigned w, int unsigned h);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_FRAME_WIDTH;
    cfg_data_i  <= CFG_DATA_W'(w);
    cfg_width    = FRAME_WIDTH_W'(w);
    @(negedge clk_i);
    cfg_index_i <= REG_FRAME_HEIGHT;
    cfg_data_i  <= CFG_DATA_W'(h);
    cfg_height   = FRAME_HEIGHT_W'(h);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    geometries++;
  endtask

  // Send pixels, with an occasional flush, until the input position is back at a frame start.
  task automatic finish_frame();
    do begin
      send_word(REQ_PIXEL, rand_pixel());
      if ((push_col != 0 || push_row != 0) && $urandom_range(99) < 3)
        send_word(REQ_FLUSH, rand_pixel());
    end while (push_col != 0 || push_row != 0);
  endtask

  task automatic drain_all();
    do begin
      if (draining && owed_edges > 1 && $urandom_range(99) < 5)
        send_word(REQ_PIXEL, rand_pixel());
      send_word(REQ_FLUSH, rand_pixel());
    end while (draining);
  endtask

  task automatic test_first_frame();
    pix_t pattern [9];
    pattern = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd128, 8'd0, 8'd1, 8'd0, 8'd254};
    settle();
    write_geometry(3, 3);
    send_word(REQ_FLUSH, 8'd0);
    for (int i = 0; i < 4; i++) send_word(REQ_PIXEL, pattern[i]);
    send_word(REQ_FLUSH, 8'hFF);
    for (int i = 4; i < 9; i++) send_word(REQ_PIXEL, pattern[i]);
    send_word(REQ_FLUSH, 8'h00);
    send_word(REQ_PIXEL, 8'hAA);
    drain_all();
  endtask

  task automatic test_tiny_frames();
    settle();
    write_geometry(0, 0);
    send_word(REQ_PIXEL, 8'hFF);
    drain_all();
    settle();
    write_geometry(1, 1);
    send_word(REQ_PIXEL, 8'h00);
    send_word(REQ_PIXEL, 8'hFF);
    drain_all();
    settle();
    write_geometry(4, 1);
    finish_frame();
    drain_all();
  endtask

  task automatic test_resize_midframe();
    settle();
    write_geometry(5, 4);
    repeat (7) send_word(REQ_PIXEL, rand_pixel());
    settle();
    // column already past the new width, row already on the last new row
    write_geometry(2, 2);
    finish_frame();
    drain_all();
  endtask

  task automatic test_wide_line();
    settle();
    write_geometry(2047, 4095);
    repeat (200) send_word(REQ_PIXEL, rand_pixel());
    settle();
    write_geometry(201, 1);
    finish_frame();
    drain_all();
  endtask

  task automatic test_backpressure();
    settle();
    write_geometry(6, 5);
    stall_left = 400;
    finish_frame();
    in_valid_i <= 1'b0;
    wait (stall_left == 0);
    drain_all();
  endtask

  task automatic test_random_frames(int unsigned target);
    int unsigned start, w, h;
    start = words_used;
    while (words_used - start < target) begin
      case ((words_used - start) * 3 / target)
        0:       set_idle(22, 47);
        1:       set_idle(47, 22);
        default: set_idle(0, 0);
      endcase
      settle();
      pick_geometry(w, h);
      write_geometry(w, h);
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, width_eff() * height_eff())) send_word(REQ_PIXEL, rand_pixel());
        if (push_col != 0 || push_row != 0) begin
          settle();
          pick_geometry(w, h);
          write_geometry(w, h);
          finish_frame();
        end
      end
      repeat ($urandom_range(1, 3)) finish_frame();
      drain_all();
    end
  endtask

  // Result receiver: random stalls, plus a long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_edges
    edge_exp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_edges.size() == 0) begin
        $error("edge_value: expected none, actual %0d", edge_value_o);
        fail_cnt++;
      end else begin
        want = expected_edges.pop_front();
        edges_checked++;
        if (edge_value_o !== want.magnitude) begin
          $error("edge_value: expected %0d, actual %0d", want.magnitude, edge_value_o);
          fail_cnt++;
        end
        if (frame_last_o !== want.frame_end) begin
          $error("frame_last: expected %0d, actual %0d", want.frame_end, frame_last_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_predictor();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    set_idle(22, 47);
    test_first_frame();
    test_tiny_frames();
    test_resize_midframe();
    test_wide_line();
    test_backpressure();
    test_random_frames(1250);
    settle();
    $display("Ran %0d pixel and flush words (%0d dropped by the block) over %0d geometries,",
             words_used, dropped_words, geometries);
    $display("checked %0d edge values including resize, tiny and wide frames.", edges_checked);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
